### rtl/maes_pkg.sv
// shared types, constants and tables of the encoder alignment sequencer
`default_nettype none

package maes_pkg;

  localparam int ALIGN_STEPS_DEF = 10;
  localparam int START_ANGLE     = 1638;   // 0.2 rad in q2.13
  localparam int HALF_PI_Q13     = 12868;
  localparam int PI_Q13          = 25736;
  localparam int SQRT3_Q16       = 113512;

  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV_W      = 34;
  localparam int DIVISOR_W  = 8;
  localparam int RECIP_W    = 32;
  localparam int TERM_IDX_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 16;

  localparam logic [TERM_IDX_W-1:0] IDX_SIN_FIRST = 4'd0;
  localparam logic [TERM_IDX_W-1:0] IDX_SIN_LAST  = 4'd4;
  localparam logic [TERM_IDX_W-1:0] IDX_COS_FIRST = 4'd5;
  localparam logic [TERM_IDX_W-1:0] IDX_COS_LAST  = 4'd10;

  localparam logic [CFG_W-1:0] MAG_RESET  = 16'd0;
  localparam logic [CFG_W-1:0] WAIT_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_MAG  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT = 1'b1;

  localparam logic [1:0] LS_RUN  = 2'd0;
  localparam logic [1:0] LS_DONE = 2'd1;
  localparam logic [1:0] LS_ERR  = 2'd2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_STEP    = 3'd1;
  localparam logic [2:0] PH_CAPTURE = 3'd2;
  localparam logic [2:0] PH_SETTLE  = 3'd3;
  localparam logic [2:0] PH_FINISH  = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FOLD,
    OP_MUL_XX,
    OP_X2,
    OP_MUL_T,
    OP_DIV_START,
    OP_MUL_R,
    OP_DIV_FIX,
    OP_DIV_END,
    OP_MUL_SV,
    OP_SV,
    OP_SIGNS,
    OP_MUL_A,
    OP_ALPHA,
    OP_MUL_B,
    OP_BETA,
    OP_MAG_AB,
    OP_MUL_K,
    OP_CLARKE,
    OP_SEQ
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [TERM_IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic need_trig;
    logic need_mag;
  } dp_status_t;

  // taylor series divisors, sine terms first then cosine terms
  function automatic logic [DIVISOR_W-1:0] term_divisor(input logic [TERM_IDX_W-1:0] idx);
    logic [DIVISOR_W-1:0] d;
    unique case (idx)
      4'd0:    d = 8'd110;
      4'd1:    d = 8'd72;
      4'd2:    d = 8'd42;
      4'd3:    d = 8'd20;
      4'd4:    d = 8'd6;
      4'd5:    d = 8'd132;
      4'd6:    d = 8'd90;
      4'd7:    d = 8'd56;
      4'd8:    d = 8'd30;
      4'd9:    d = 8'd12;
      4'd10:   d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), same order as the divisors
  function automatic logic [RECIP_W-1:0] term_reciprocal(input logic [TERM_IDX_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    unique case (idx)
      4'd0:    r = 32'd39045157;
      4'd1:    r = 32'd59652323;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd214748364;
      4'd4:    r = 32'd715827882;
      4'd5:    r = 32'd32537631;
      4'd6:    r = 32'd47721858;
      4'd7:    r = 32'd76695844;
      4'd8:    r = 32'd143165576;
      4'd9:    r = 32'd357913941;
      4'd10:   r = 32'd2147483648;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/maes_datapath.sv
// sequence state, shared multiplier, reciprocal divider and drive arithmetic
`default_nettype none

module maes_datapath #(
  parameter int ALIGN_STEPS = maes_pkg::ALIGN_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_en,
  input  wire logic [maes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [maes_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [31:0]                    now_ms,
  input  wire logic                           zero_capture_ok,
  input  wire maes_pkg::dp_cmd_t              cmd,
  output maes_pkg::dp_status_t                status,
  output logic [1:0]                          loop_status,
  output logic                                drive_update,
  output logic signed [15:0]                  volt_a,
  output logic signed [15:0]                  volt_b,
  output logic signed [15:0]                  volt_c,
  output logic                                capture_strobe
);
  import maes_pkg::*;

  localparam int ANGLE_STEP = (2 * START_ANGLE + ALIGN_STEPS) / (2 * ALIGN_STEPS);
  localparam logic [3:0]          STEPS     = 4'(ALIGN_STEPS);
  localparam logic signed [15:0]  START_Q13 = 16'(START_ANGLE);
  localparam logic signed [15:0]  STEP_Q13  = 16'(ANGLE_STEP);
  localparam logic signed [16:0]  HALF_PI_S = 17'(HALF_PI_Q13);
  localparam logic signed [16:0]  PI_S      = 17'(PI_Q13);
  localparam logic signed [MUL_W-1:0] ONE_Q30 = {{(MUL_W-31){1'b0}}, 1'b1, 30'd0};

  // configuration and sequence state
  logic [15:0]        drive_magnitude;
  logic [15:0]        wait_ms;
  logic [2:0]         seq_phase;
  logic [3:0]         sub_count;
  logic signed [15:0] angle;
  logic [31:0]        deadline;

  // working registers
  logic [31:0]              now_q;
  logic                     ok_q;
  logic                     flip;
  logic                     sneg;
  logic [30:0]              x;
  logic [31:0]              x2;
  logic signed [MUL_W-1:0]  t;
  logic signed [MUL_W-1:0]  s_val;
  logic signed [MUL_W-1:0]  c_val;
  logic signed [PROD_W-1:0] prod;
  logic signed [17:0]       alpha;
  logic signed [17:0]       beta;
  logic signed [15:0]       va;
  logic signed [15:0]       vb;
  logic signed [15:0]       vc;
  logic [DIVISOR_W-1:0]     div_d;
  logic [DIV_W-1:0]         div_q;
  logic                     div_neg;

  logic                           due;
  logic [31:0]                    next_deadline;
  logic signed [16:0]             a_ext;
  logic signed [16:0]             a_fold;
  logic signed [16:0]             a_abs;
  logic                           fold_flip;
  logic signed [MUL_W-1:0]        mul_a;
  logic signed [MUL_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]       prod_s30;
  logic signed [PROD_W-1:0]       prod_mag;
  logic [DIV_W-1:0]               q_est;
  logic [DIV_W+DIVISOR_W-1:0]     fix_prod;
  logic [DIV_W+DIVISOR_W-1:0]     fix_rem;
  logic                           fix_up;
  logic signed [MUL_W-1:0]        quot;
  logic signed [39:0]             alpha_hi;
  logic signed [39:0]             k_term;
  logic                           is_mul;

  function automatic logic signed [17:0] rnd30(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] m;
    m = v[PROD_W-1] ? -v : v;
    m = (m + (PROD_W'(1) <<< 29)) >>> 30;
    return v[PROD_W-1] ? -m[17:0] : m[17:0];
  endfunction

  function automatic logic signed [23:0] rnd17(input logic signed [39:0] v);
    logic signed [39:0] m;
    m = v[39] ? -v : v;
    m = (m + (40'sd1 <<< 16)) >>> 17;
    return v[39] ? -m[23:0] : m[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign due           = now_q >= deadline;
  assign next_deadline = now_q + 32'(wait_ms);

  assign status.need_trig = due && (seq_phase == PH_STEP) && (sub_count < STEPS);
  assign status.need_mag  = due && (seq_phase == PH_STEP) && (sub_count == STEPS);

  // fold into [-pi/2, pi/2]
  always_comb begin
    a_ext     = 17'(angle);
    a_fold    = a_ext;
    fold_flip = 1'b0;
    if (a_ext > HALF_PI_S) begin
      a_fold    = a_ext - PI_S;
      fold_flip = 1'b1;
    end else if (a_ext < -HALF_PI_S) begin
      a_fold    = a_ext + PI_S;
      fold_flip = 1'b1;
    end
    a_abs = a_fold[16] ? -a_fold : a_fold;
  end

  // shared multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    unique case (cmd.op)
      OP_MUL_XX: begin
        mul_a = MUL_W'(x);
        mul_b = MUL_W'(x);
      end
      OP_MUL_T: begin
        mul_a = MUL_W'(x2);
        mul_b = t;
      end
      OP_MUL_R: begin
        mul_a = MUL_W'(div_q);
        mul_b = MUL_W'(term_reciprocal(cmd.idx));
      end
      OP_MUL_SV: begin
        mul_a = MUL_W'(x);
        mul_b = t;
      end
      OP_MUL_A: begin
        mul_a = c_val;
        mul_b = MUL_W'(drive_magnitude);
      end
      OP_MUL_B: begin
        mul_a = s_val;
        mul_b = MUL_W'(drive_magnitude);
      end
      OP_MUL_K: begin
        mul_a = MUL_W'(beta);
        mul_b = MUL_W'(SQRT3_Q16);
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign prod_s30 = prod >>> 30;
  assign prod_mag = prod_s30[PROD_W-1] ? -prod_s30 : prod_s30;

  // quotient estimate from the reciprocal is at most one short, one correction step
  assign q_est    = prod[DIV_W+31:32];
  assign fix_prod = q_est * div_d;
  assign fix_rem  = {{DIVISOR_W{1'b0}}, div_q} - fix_prod;
  assign fix_up   = fix_rem >= {{DIV_W{1'b0}}, div_d};
  assign quot     = div_neg ? -MUL_W'(div_q) : MUL_W'(div_q);

  assign alpha_hi = 40'(alpha) <<< 16;
  assign k_term   = prod[39:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_magnitude <= MAG_RESET;
      wait_ms         <= WAIT_RESET;
      seq_phase       <= PH_IDLE;
      sub_count       <= '0;
      angle           <= '0;
      deadline        <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_MAG:  drive_magnitude <= cfg_data;
          REG_WAIT: wait_ms         <= cfg_data;
        endcase
      end
      if (cmd.op == OP_SEQ && due) begin
        unique case (seq_phase)
          PH_IDLE: begin
            angle     <= START_Q13;
            seq_phase <= PH_STEP;
            deadline  <= next_deadline;
          end
          PH_STEP: begin
            if (sub_count < STEPS) begin
              if (angle > 16'sd0) begin
                angle <= STEP_Q13 - angle;
              end else begin
                angle <= -angle - STEP_Q13;
              end
              sub_count <= sub_count + 1'b1;
            end else if (sub_count == STEPS) begin
              sub_count <= sub_count + 1'b1;
            end else begin
              sub_count <= '0;
              seq_phase <= PH_CAPTURE;
            end
            deadline <= next_deadline;
          end
          PH_CAPTURE: begin
            if (!ok_q) begin
              seq_phase <= PH_IDLE;
            end else begin
              seq_phase <= PH_SETTLE;
              deadline  <= next_deadline;
            end
          end
          PH_SETTLE: begin
            seq_phase <= PH_FINISH;
            deadline  <= next_deadline;
          end
          default: seq_phase <= PH_IDLE;
        endcase
      end
    end
  end

  // arithmetic and result registers
  always_ff @(posedge clk) begin
    if (is_mul) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        now_q <= now_ms;
        ok_q  <= zero_capture_ok;
      end
      OP_FOLD: begin
        flip <= fold_flip;
        sneg <= a_fold[16];
        x    <= {a_abs[13:0], 17'd0};
      end
      OP_X2: begin
        x2 <= prod_s30[31:0];
        t  <= ONE_Q30;
      end
      OP_DIV_START: begin
        div_neg <= prod_s30[PROD_W-1];
        div_q   <= prod_mag[DIV_W-1:0];
        div_d   <= term_divisor(cmd.idx);
      end
      OP_DIV_FIX: div_q <= q_est + {{(DIV_W-1){1'b0}}, fix_up};
      OP_DIV_END: t <= ONE_Q30 - quot;
      OP_SV: begin
        s_val <= prod_s30[MUL_W-1:0];
        t     <= ONE_Q30;
      end
      OP_SIGNS: begin
        s_val <= (sneg ^ flip) ? -s_val : s_val;
        c_val <= flip ? -t : t;
      end
      OP_ALPHA: alpha <= rnd30(prod);
      OP_BETA:  beta  <= rnd30(prod);
      OP_MAG_AB: begin
        alpha <= 18'(drive_magnitude);
        beta  <= '0;
      end
      OP_CLARKE: begin
        va <= sat16(24'(alpha));
        vb <= sat16(rnd17(k_term - alpha_hi));
        vc <= sat16(rnd17(-alpha_hi - k_term));
      end
      OP_SEQ: begin
        loop_status    <= LS_RUN;
        drive_update   <= 1'b0;
        volt_a         <= '0;
        volt_b         <= '0;
        volt_c         <= '0;
        capture_strobe <= 1'b0;
        if (due) begin
          unique case (seq_phase)
            PH_IDLE: ;
            PH_STEP: begin
              if (sub_count <= STEPS) begin
                drive_update <= 1'b1;
                volt_a       <= va;
                volt_b       <= vb;
                volt_c       <= vc;
              end
            end
            PH_CAPTURE: begin
              capture_strobe <= 1'b1;
              if (!ok_q) begin
                drive_update <= 1'b1;
                loop_status  <= LS_ERR;
              end
            end
            PH_SETTLE: drive_update <= 1'b1;
            default:   loop_status  <= LS_DONE;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/maes_ctrl.sv
// controller state machine of the encoder alignment sequencer
`default_nettype none

module maes_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire maes_pkg::dp_status_t status,
  output maes_pkg::dp_cmd_t         cmd
);
  import maes_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE      = 21'h000001,
    ST_DECIDE    = 21'h000002,
    ST_FOLD      = 21'h000004,
    ST_MUL_XX    = 21'h000008,
    ST_X2        = 21'h000010,
    ST_MUL_T     = 21'h000020,
    ST_DIV_START = 21'h000040,
    ST_MUL_R     = 21'h000080,
    ST_DIV_FIX   = 21'h000100,
    ST_DIV_END   = 21'h000200,
    ST_MUL_SV    = 21'h000400,
    ST_SV        = 21'h000800,
    ST_SIGNS     = 21'h001000,
    ST_MUL_A     = 21'h002000,
    ST_ALPHA     = 21'h004000,
    ST_MUL_B     = 21'h008000,
    ST_BETA      = 21'h010000,
    ST_MAG_AB    = 21'h020000,
    ST_MUL_K     = 21'h040000,
    ST_CLARKE    = 21'h080000,
    ST_SEQ       = 21'h100000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [TERM_IDX_W-1:0] idx;
  logic [TERM_IDX_W-1:0] idx_next;
  logic                  seq_fire;

  assign in_ready = state == ST_IDLE;
  assign seq_fire = (state == ST_SEQ) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.need_trig) begin
          idx_next   = IDX_SIN_FIRST;
          state_next = ST_FOLD;
        end else if (status.need_mag) begin
          state_next = ST_MAG_AB;
        end else begin
          state_next = ST_SEQ;
        end
      end
      ST_FOLD: begin
        cmd.op     = OP_FOLD;
        state_next = ST_MUL_XX;
      end
      ST_MUL_XX: begin
        cmd.op     = OP_MUL_XX;
        state_next = ST_X2;
      end
      ST_X2: begin
        cmd.op     = OP_X2;
        state_next = ST_MUL_T;
      end
      ST_MUL_T: begin
        cmd.op     = OP_MUL_T;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_MUL_R;
      end
      ST_MUL_R: begin
        cmd.op     = OP_MUL_R;
        state_next = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.op     = OP_DIV_FIX;
        state_next = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.op = OP_DIV_END;
        if (idx == IDX_SIN_LAST) begin
          state_next = ST_MUL_SV;
        end else if (idx == IDX_COS_LAST) begin
          state_next = ST_SIGNS;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_MUL_T;
        end
      end
      ST_MUL_SV: begin
        cmd.op     = OP_MUL_SV;
        state_next = ST_SV;
      end
      ST_SV: begin
        cmd.op     = OP_SV;
        idx_next   = IDX_COS_FIRST;
        state_next = ST_MUL_T;
      end
      ST_SIGNS: begin
        cmd.op     = OP_SIGNS;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_ALPHA;
      end
      ST_ALPHA: begin
        cmd.op     = OP_ALPHA;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_BETA;
      end
      ST_BETA: begin
        cmd.op     = OP_BETA;
        state_next = ST_MUL_K;
      end
      ST_MAG_AB: begin
        cmd.op     = OP_MAG_AB;
        state_next = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.op     = OP_MUL_K;
        state_next = ST_CLARKE;
      end
      ST_CLARKE: begin
        cmd.op     = OP_CLARKE;
        state_next = ST_SEQ;
      end
      ST_SEQ: begin
        if (seq_fire) begin
          cmd.op     = OP_SEQ;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (seq_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/motor_encoder_alignment_sequencer.sv
// top level of the motor encoder alignment sequencer
//
// usage: one poll per input transfer (now_ms, zero_capture_ok), exactly one
// result transfer back per poll (loop_status, drive_update, volt_a/b/c,
// capture_strobe). both channels are valid/ready; the result sits in an
// output register, so the next poll is taken while a result still waits.
// work from input transfer to result valid:
//   alignment step with sin/cos: eleven taylor terms, each worked as
//     multiply, take magnitude, reciprocal multiply, correct, update
//   final alpha-only step: magnitude taken as alpha, no sin/cos series
//   any other poll (not due, start, capture, settle, finish): result only
// a new poll is accepted in the cycle after the result register is loaded.
// if the receiver stalls, the finished result holds and the next poll is
// worked up to the result stage, then waits there for the register to free.
// configuration is a plain write port (index 0 drive magnitude, index 1
// wait in ms), to be used only while idle.
// reset (rst, synchronous) clears the phase, step count, angle, deadline,
// restores the register defaults and empties the output register.
`default_nettype none

module motor_encoder_alignment_sequencer #(
  parameter int ALIGN_STEPS = maes_pkg::ALIGN_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_write_en,
  input  wire logic [maes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [maes_pkg::CFG_W-1:0]     cfg_data,
  // poll channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [31:0]                    now_ms,
  input  wire logic                           zero_capture_ok,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          loop_status,
  output logic                                drive_update,
  output logic signed [15:0]                  volt_a,
  output logic signed [15:0]                  volt_b,
  output logic signed [15:0]                  volt_c,
  output logic                                capture_strobe
);
  import maes_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing of micro-steps and the result handshake
  maes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // phase state, sin/cos series, inverse clarke and the result register
  maes_datapath #(
    .ALIGN_STEPS (ALIGN_STEPS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .now_ms          (now_ms),
    .zero_capture_ok (zero_capture_ok),
    .cmd             (cmd),
    .status          (status),
    .loop_status     (loop_status),
    .drive_update    (drive_update),
    .volt_a          (volt_a),
    .volt_b          (volt_b),
    .volt_c          (volt_c),
    .capture_strobe  (capture_strobe)
  );

`ifndef SYNTHESIS
  // no voltages unless a drive update is reported
  a_idle_volts: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_update |-> volt_a == 16'sd0 && volt_b == 16'sd0 && volt_c == 16'sd0)
    else $error("volts driven without drive_update");

  // an error only comes from a failed capture, which drives zero
  a_err_capture: assert property (@(posedge clk) disable iff (rst)
    out_valid && loop_status == LS_ERR |-> capture_strobe && drive_update)
    else $error("error result without capture and zero drive");

  // completion drives nothing and requests no capture
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && loop_status == LS_DONE |-> !drive_update && !capture_strobe)
    else $error("completion result with drive or capture");
`endif

endmodule

`default_nettype wire
